>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while reset is released
`define KVP_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("kvp assertion failed");

// checked at every edge, reset included
`define KVP_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) else $error("kvp assertion failed");

`endif

>>> rtl/kvp_pkg.sv
package kvp_pkg;

  localparam int KEY_NUM = 18;
  localparam int ERR_NUM = 12;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [4:0] K_PID      = 5'd0;
  localparam logic [4:0] K_FW       = 5'd1;
  localparam logic [4:0] K_SER      = 5'd2;
  localparam logic [4:0] K_CS       = 5'd7;
  localparam logic [4:0] K_ERR      = 5'd8;
  localparam logic [4:0] K_LOAD     = 5'd9;
  localparam logic [4:0] K_CHECKSUM = 5'd17;
  localparam logic [4:0] K_UNKNOWN  = 5'd31;

  localparam int F_SIGN   = 0;
  localparam int F_STOP   = 1;
  localparam int F_SAT    = 2;
  localparam int F_PREFIX = 3;

  localparam logic [7:0] PRINT_LO = 8'd33;
  localparam logic [7:0] PRINT_HI = 8'd126;

  localparam logic [63:0] KEY_TXT [KEY_NUM] = '{
    {"PID", 40'h0}, {"FW", 48'h0}, {"SER#", 32'h0}, {"V", 56'h0}, {"I", 56'h0},
    {"VPV", 40'h0}, {"PPV", 40'h0}, {"CS", 48'h0}, {"ERR", 40'h0},
    {"LOAD", 32'h0}, {"IL", 48'h0}, {"H19", 40'h0}, {"H20", 40'h0},
    {"H21", 40'h0}, {"H22", 40'h0}, {"H23", 40'h0}, {"HSDS", 32'h0},
    "Checksum"
  };
  localparam logic [4:0] KEY_LEN [KEY_NUM] = '{
    5'd3, 5'd2, 5'd4, 5'd1, 5'd1, 5'd3, 5'd3, 5'd2, 5'd3, 5'd4, 5'd2,
    5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd4, 5'd8
  };

  localparam logic [23:0] ERR_TXT [ERR_NUM] = '{
    {"0", 16'h0}, {"2", 16'h0}, {"17", 8'h0}, {"18", 8'h0}, {"19", 8'h0},
    {"20", 8'h0}, {"21", 8'h0}, {"26", 8'h0}, {"33", 8'h0}, {"34", 8'h0},
    {"38", 8'h0}, "116"
  };
  localparam logic [4:0] ERR_LEN [ERR_NUM] = '{
    5'd1, 5'd1, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd3
  };

  typedef struct packed {
    logic        has_pair;
    logic [4:0]  field_id;
    logic [31:0] field_value;
    logic [3:0]  decoded_code;
    logic        has_done;
    logic        empty;
  } kvp_event_t;

  // first chars sit at the top of vec
  function automatic logic [4:0] key_lookup(input logic [63:0] vec, input logic [4:0] len);
    logic [63:0] mask;
    logic [4:0]  k;
    mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> {len, 3'b000});
    k = K_UNKNOWN;
    for (int i = KEY_NUM - 1; i >= 0; i--) begin
      if (len == KEY_LEN[i] && (vec & mask) == KEY_TXT[i]) k = 5'(i);
    end
    return k;
  endfunction

  function automatic logic [3:0] err_lookup(input logic [23:0] vec, input logic [4:0] len);
    logic [23:0] mask;
    logic [3:0]  c;
    mask = ~(24'hFF_FFFF >> {len, 3'b000});
    c = 4'd0;
    for (int i = ERR_NUM - 1; i >= 0; i--) begin
      if (len == ERR_LEN[i] && (vec & mask) == ERR_TXT[i]) c = 4'(i + 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "z") d = c - "a" + 8'd10;
    else if (c >= "A" && c <= "Z") d = c - "A" + 8'd10;
    else d = 8'd255;
    return d;
  endfunction

endpackage

>>> rtl/kvp_front.sv
module kvp_front #(
  parameter int KEY_CHARS   = 8,
  parameter int VALUE_CHARS = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               frame_end,
  output logic               ev_push,
  output kvp_pkg::kvp_event_t ev
);

  localparam int KLW = $clog2(KEY_CHARS + 2);
  localparam int KIW = $clog2(KEY_CHARS);
  localparam int VLW = $clog2(VALUE_CHARS + 1);
  localparam int VIW = $clog2(VALUE_CHARS);

  typedef enum logic [2:0] {PH_IDLE, PH_KEY, PH_GAP, PH_VALUE, PH_CKSUM} phase_t;

  phase_t      phase_r, phase_nxt, phase_m;
  logic [7:0]  kc_r [KEY_CHARS];
  logic [7:0]  kc_m [KEY_CHARS];
  logic [KLW-1:0] kl_r, kl_m, kl_nxt;
  logic [7:0]  vc_r [VALUE_CHARS];
  logic [7:0]  vc_m [VALUE_CHARS];
  logic [VLW-1:0] vl_r, vl_m, vl_nxt, vl_e;
  logic [31:0] acc_r, acc_m, acc_nxt, acc_e;
  logic [3:0]  flg_r, flg_m, flg_nxt, flg_e;
  logic [4:0]  ck_r, ck_m, ck_nxt, key_e;
  logic        seen_r, seen_nxt;

  logic        pr, add_en, val_clear, fin_key, emit_now, key_ok;
  logic [63:0] key_vec;
  logic [4:0]  lookup_m;
  logic        base16, s;
  logic [7:0]  d, s_char;
  logic [35:0] m;
  logic [23:0] val_vec;
  logic [31:0] num_val;

  assign pr = data_byte >= kvp_pkg::PRINT_LO && data_byte <= kvp_pkg::PRINT_HI;

  // key buffer
  always_comb begin
    kc_m = kc_r;
    kl_m = kl_r;
    if (pr && phase_r == PH_IDLE) begin
      kl_m = KLW'(1);
      kc_m[0] = data_byte;
    end else if (pr && phase_r == PH_KEY) begin
      if (kl_r < KLW'(KEY_CHARS)) kc_m[kl_r[KIW-1:0]] = data_byte;
      if (kl_r <= KLW'(KEY_CHARS)) kl_m = kl_r + KLW'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) key_vec[63 - 8*i -: 8] = kc_m[i];
  end

  assign lookup_m = (kl_m <= KLW'(KEY_CHARS)) ? kvp_pkg::key_lookup(key_vec, 5'(kl_m))
                                              : kvp_pkg::K_UNKNOWN;

  // value buffer and number accumulation
  assign add_en = pr && (phase_r == PH_GAP || phase_r == PH_VALUE) &&
                  vl_r < VLW'(VALUE_CHARS);
  assign base16 = ck_r == kvp_pkg::K_PID;
  assign d = kvp_pkg::digit_of(data_byte);
  assign s = vl_r != '0 && (vc_r[0] == "+" || vc_r[0] == "-");
  assign s_char = s ? vc_r[1] : vc_r[0];

  always_comb begin
    vc_m = vc_r;
    vl_m = vl_r;
    acc_m = acc_r;
    flg_m = flg_r;
    m = '0;
    if (add_en) begin
      vc_m[vl_r[VIW-1:0]] = data_byte;
      vl_m = vl_r + VLW'(1);
      if (!flg_r[kvp_pkg::F_STOP]) begin
        if (vl_r == '0 && (data_byte == "+" || data_byte == "-")) begin
          if (data_byte == "-") flg_m[kvp_pkg::F_SIGN] = 1'b1;
        end else if (base16 && !flg_r[kvp_pkg::F_PREFIX] &&
                     (data_byte == "x" || data_byte == "X")) begin
          if (vl_r == VLW'(s) + VLW'(1) && s_char == "0") flg_m[kvp_pkg::F_PREFIX] = 1'b1;
          else flg_m[kvp_pkg::F_STOP] = 1'b1;
        end else if (d >= (base16 ? 8'd16 : 8'd10)) begin
          flg_m[kvp_pkg::F_STOP] = 1'b1;
        end else begin
          if (base16) m = {acc_r, 4'b0000} + {28'd0, d};
          else m = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {28'd0, d};
          if (m > 36'h0_8000_0000) begin
            acc_m = 32'h8000_0000;
            flg_m[kvp_pkg::F_SAT] = 1'b1;
          end else begin
            acc_m = m[31:0];
          end
        end
      end
    end
  end

  // phase
  always_comb begin
    phase_m = phase_r;
    ck_m = ck_r;
    val_clear = 1'b0;
    unique case (phase_r)
      PH_IDLE:  if (pr) phase_m = PH_KEY;
      PH_KEY: begin
        if (!pr) begin
          ck_m = lookup_m;
          val_clear = 1'b1;
          phase_m = (lookup_m == kvp_pkg::K_CHECKSUM) ? PH_CKSUM : PH_GAP;
        end
      end
      PH_GAP:   if (pr) phase_m = PH_VALUE;
      PH_VALUE: if (!pr) phase_m = PH_IDLE;
      PH_CKSUM: phase_m = PH_IDLE;
      default:  phase_m = PH_IDLE;
    endcase
  end

  assign fin_key = frame_end && phase_m == PH_KEY;
  assign key_e = fin_key ? lookup_m : ck_m;
  assign vl_e  = (fin_key || val_clear) ? '0 : vl_m;
  assign acc_e = (fin_key || val_clear) ? '0 : acc_m;
  assign flg_e = (fin_key || val_clear) ? '0 : flg_m;

  assign emit_now = (phase_r == PH_VALUE && !pr) || phase_r == PH_CKSUM ||
                    (frame_end && ((fin_key && lookup_m != kvp_pkg::K_CHECKSUM) ||
                                   phase_m == PH_GAP || phase_m == PH_VALUE));
  assign key_ok = key_e < 5'(kvp_pkg::KEY_NUM) && key_e != kvp_pkg::K_FW &&
                  key_e != kvp_pkg::K_SER;

  assign val_vec = {vc_m[0], vc_m[1], vc_m[2]};

  always_comb begin
    if (flg_e[kvp_pkg::F_SIGN]) num_val = acc_e[31] ? 32'h8000_0000 : (32'd0 - acc_e);
    else num_val = acc_e[31] ? 32'h7FFF_FFFF : acc_e;
  end

  always_comb begin
    ev = '0;
    ev.has_pair = emit_now && key_ok;
    ev.field_id = key_e;
    ev.has_done = frame_end;
    ev.empty = !(seen_r || pr);
    priority case (key_e)
      kvp_pkg::K_CHECKSUM: ev.field_value = {24'd0, data_byte};
      kvp_pkg::K_CS: begin
        if (vl_e != '0 && vc_m[0] >= "0" && vc_m[0] <= "5")
          ev.decoded_code = 4'(vc_m[0] - "0" + 8'd1);
      end
      kvp_pkg::K_ERR:  ev.decoded_code = kvp_pkg::err_lookup(val_vec, 5'(vl_e));
      kvp_pkg::K_LOAD: begin
        if (vl_e == VLW'(2) && vc_m[0] == "O" && vc_m[1] == "N") ev.decoded_code = 4'd1;
      end
      default: ev.field_value = num_val;
    endcase
  end

  assign ev_push = accept && (ev.has_pair || frame_end);

  always_comb begin
    phase_nxt = phase_m;
    kl_nxt = kl_m;
    vl_nxt = vl_e;
    acc_nxt = acc_e;
    flg_nxt = flg_e;
    ck_nxt = ck_m;
    seen_nxt = seen_r || pr;
    if (frame_end) begin
      phase_nxt = PH_IDLE;
      kl_nxt = '0;
      vl_nxt = '0;
      acc_nxt = '0;
      flg_nxt = '0;
      ck_nxt = kvp_pkg::K_UNKNOWN;
      seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kl_r <= '0;
      vl_r <= '0;
      acc_r <= '0;
      flg_r <= '0;
      ck_r <= kvp_pkg::K_UNKNOWN;
      seen_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kl_r <= kl_nxt;
      vl_r <= vl_nxt;
      acc_r <= acc_nxt;
      flg_r <= flg_nxt;
      ck_r <= ck_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kc_r <= kc_m;
      vc_r <= vc_m;
    end
  end

endmodule

>>> rtl/kvp_back.sv
module kvp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ev_push,
  input  kvp_pkg::kvp_event_t ev,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output logic [4:0]          field_id,
  output logic signed [31:0]  field_value,
  output logic [3:0]          decoded_code,
  output logic                pair_valid,
  output logic                frame_done,
  output logic                frame_empty,
  output logic                last_result
);

  localparam int QD  = kvp_pkg::QUEUE_DEPTH;
  localparam int QAW = $clog2(QD);

  kvp_pkg::kvp_event_t q_r [QD];
  kvp_pkg::kvp_event_t head;
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r;
  logic           sub_r, two, pop_ok, deq;

  assign full  = cnt_r == (QAW+1)'(QD);
  assign empty = cnt_r == '0;
  assign head  = q_r[rd_r];
  assign two   = head.has_pair && head.has_done;
  assign pop_ok = pop && !empty;
  assign deq   = pop_ok && !(two && !sub_r);

  always_comb begin
    if (!sub_r && head.has_pair) begin
      field_id     = head.field_id;
      field_value  = head.field_value;
      decoded_code = head.decoded_code;
      pair_valid   = 1'b1;
      frame_done   = 1'b0;
      frame_empty  = 1'b0;
      last_result  = !head.has_done;
    end else begin
      field_id     = '0;
      field_value  = '0;
      decoded_code = '0;
      pair_valid   = 1'b0;
      frame_done   = 1'b1;
      frame_empty  = head.empty;
      last_result  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
      sub_r <= 1'b0;
    end else begin
      if (ev_push) wr_r <= wr_r + QAW'(1);
      if (deq) rd_r <= rd_r + QAW'(1);
      cnt_r <= cnt_r + (QAW+1)'(ev_push) - (QAW+1)'(deq);
      if (pop_ok) sub_r <= !deq;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_push) q_r[wr_r] <= ev;
  end

endmodule

>>> rtl/key_value_frame_parser.sv
// Key/value text frame parser. Feed one byte per transaction on the input queue; a byte is
// taken every cycle while in_full is low. Each byte yields zero, one or two results (a pair
// and/or the frame-done result) that appear on the output queue the cycle after the byte is
// taken, one result per cycle while out_pop is high. The front end keeps all parse state and
// settles a byte in the cycle it is taken; a four-entry event queue sits between it and the
// result port, so in_full rises only when four events wait, and a two-result byte takes two pops.
module key_value_frame_parser #(
  parameter int KEY_CHARS   = 8,
  parameter int VALUE_CHARS = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_end,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [4:0]         out_field_id,
  output logic signed [31:0] out_field_value,
  output logic [3:0]         out_decoded_code,
  output logic               out_pair_valid,
  output logic               out_frame_done,
  output logic               out_frame_empty,
  output logic               out_last_result
);

  kvp_pkg::kvp_event_t ev;
  logic ev_push, accept;

  assign accept = in_push && !in_full;

  kvp_front #(.KEY_CHARS(KEY_CHARS), .VALUE_CHARS(VALUE_CHARS)) u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .data_byte(in_data_byte),
    .frame_end(in_frame_end), .ev_push(ev_push), .ev(ev)
  );

  kvp_back u_back (
    .clk(clk), .rst_n(rst_n), .ev_push(ev_push), .ev(ev), .full(in_full),
    .empty(out_empty), .pop(out_pop), .field_id(out_field_id),
    .field_value(out_field_value), .decoded_code(out_decoded_code),
    .pair_valid(out_pair_valid), .frame_done(out_frame_done),
    .frame_empty(out_frame_empty), .last_result(out_last_result)
  );

endmodule

>>> rtl/kvp_checker.sv
`include "assert_macros.svh"

module kvp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [4:0]  out_field_id,
  input logic [31:0] out_field_value,
  input logic        out_pair_valid,
  input logic        out_frame_done,
  input logic        out_last_result
);

  // done result closes the byte
  `KVP_ASSERT(a_done_last, clk, rst_n, out_frame_done && !out_empty |-> out_last_result)
  // a result is either a pair or a done
  `KVP_ASSERT(a_kind, clk, rst_n, !out_empty |-> (out_pair_valid != out_frame_done))
  // a stalled result holds
  `KVP_ASSERT(a_hold, clk, rst_n, !out_empty && !out_pop |=> !out_empty && $stable(out_field_id) && $stable(out_field_value))
  // nothing waits right after reset
  `KVP_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> out_empty && !in_full)

endmodule

bind key_value_frame_parser kvp_checker u_kvp_checker (
  .clk(clk), .rst_n(rst_n), .in_full(in_full),
  .out_empty(out_empty), .out_pop(out_pop), .out_field_id(out_field_id),
  .out_field_value(out_field_value), .out_pair_valid(out_pair_valid),
  .out_frame_done(out_frame_done), .out_last_result(out_last_result)
);

>>> tb/tb_key_value_frame_parser.sv
`timescale 1ns / 100ps

module tb_key_value_frame_parser;

  localparam int KEY_MAX = 8;
  localparam int VAL_MAX = 11;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum logic [2:0] {
    PH_IDLE, PH_KEY, PH_GAP, PH_VALUE, PH_CKSUM
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } byte_txn_t;

  typedef struct packed {
    logic [4:0]  field_id;
    logic [31:0] field_value;
    logic [3:0]  decoded_code;
    logic        pair_valid;
    logic        frame_done;
    logic        frame_empty;
    logic        last_result;
  } frame_result_t;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic [7:0] in_data_byte;
  logic in_frame_end;
  logic out_empty;
  logic out_pop;
  logic [4:0] out_field_id;
  logic signed [31:0] out_field_value;
  logic [3:0] out_decoded_code;
  logic out_pair_valid;
  logic out_frame_done;
  logic out_frame_empty;
  logic out_last_result;

  key_value_frame_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_data_byte(in_data_byte), .in_frame_end(in_frame_end),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_field_id(out_field_id), .out_field_value(out_field_value),
    .out_decoded_code(out_decoded_code), .out_pair_valid(out_pair_valid),
    .out_frame_done(out_frame_done), .out_frame_empty(out_frame_empty),
    .out_last_result(out_last_result)
  );

  byte_txn_t pending_bytes[$];
  frame_result_t expected_results[$];
  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;
  bit send_hold;
  int idle_cycles;

  // parser shadow state
  phase_t ph;
  logic [7:0] kbuf [KEY_MAX];
  int klen;
  logic [7:0] vbuf [VAL_MAX];
  int vlen;
  logic [31:0] accum;
  bit neg, stopped, prefixed;
  logic [4:0] cur_key;
  bit printable_seen;
  frame_result_t step_out[$];

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic string key_name(int k);
    string names[18] = '{"PID", "FW", "SER#", "V", "I", "VPV", "PPV", "CS", "ERR", "LOAD",
                         "IL", "H19", "H20", "H21", "H22", "H23", "HSDS", "Checksum"};
    return names[k];
  endfunction

  task automatic reset_shadow();
    ph = PH_IDLE;
    klen = 0;
    vlen = 0;
    accum = '0;
    {neg, stopped, prefixed} = '0;
    cur_key = kvp_pkg::K_UNKNOWN;
    printable_seen = 1'b0;
  endtask

  task automatic close_key();
    string s;
    s = "";
    cur_key = kvp_pkg::K_UNKNOWN;
    if (klen <= KEY_MAX) begin
      for (int i = 0; i < klen; i++) s = {s, string'(kbuf[i])};
      for (int i = 0; i < 18; i++) if (s == key_name(i)) begin
        cur_key = 5'(i);
        break;
      end
    end
    vlen = 0;
    accum = '0;
    {neg, stopped, prefixed} = '0;
    ph = (cur_key == kvp_pkg::K_CHECKSUM) ? PH_CKSUM : PH_GAP;
  endtask

  function automatic int digit_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "z") return c - "a" + 10;
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    return 255;
  endfunction

  task automatic take_value_char(logic [7:0] c);
    int base;
    int d;
    int s;
    logic [63:0] m;
    if (vlen >= VAL_MAX) return;
    base = (cur_key == kvp_pkg::K_PID) ? 16 : 10;
    if (!stopped) begin
      if (vlen == 0 && (c == "+" || c == "-")) begin
        if (c == "-") neg = 1'b1;
      end else if (base == 16 && !prefixed && (c == "x" || c == "X")) begin
        s = (vlen > 0 && (vbuf[0] == "+" || vbuf[0] == "-")) ? 1 : 0;
        if (vlen == s + 1 && vbuf[s] == "0") prefixed = 1'b1;
        else stopped = 1'b1;
      end else begin
        d = digit_val(c);
        if (d >= base) stopped = 1'b1;
        else begin
          m = 64'(accum) * base + d;
          if (m > 64'h8000_0000) m = 64'h8000_0000;
          accum = m[31:0];
        end
      end
    end
    vbuf[vlen] = c;
    vlen++;
  endtask

  task automatic add_pair(logic [7:0] raw);
    frame_result_t r;
    string v;
    string errs[12] = '{"0", "2", "17", "18", "19", "20", "21", "26", "33", "34", "38",
                        "116"};
    if (cur_key >= 18 || cur_key == kvp_pkg::K_FW || cur_key == kvp_pkg::K_SER) return;
    r = '0;
    r.field_id = cur_key;
    r.pair_valid = 1'b1;
    v = "";
    for (int i = 0; i < vlen; i++) v = {v, string'(vbuf[i])};
    if (cur_key == kvp_pkg::K_CHECKSUM) r.field_value = {24'h0, raw};
    else if (cur_key == kvp_pkg::K_CS) begin
      if (vlen > 0 && vbuf[0] >= "0" && vbuf[0] <= "5") r.decoded_code = 4'(vbuf[0] - "0" + 1);
    end else if (cur_key == kvp_pkg::K_ERR) begin
      for (int i = 0; i < 12; i++) if (v == errs[i]) begin
        r.decoded_code = 4'(i + 1);
        break;
      end
    end else if (cur_key == kvp_pkg::K_LOAD) begin
      if (v == "ON") r.decoded_code = 4'd1;
    end else if (neg) r.field_value = (accum >= 32'h8000_0000) ? 32'h8000_0000 : -accum;
    else r.field_value = (accum > 32'h7fff_ffff) ? 32'h7fff_ffff : accum;
    step_out.push_back(r);
  endtask

  task automatic predict_byte(byte_txn_t t);
    bit pr;
    frame_result_t r;
    step_out = {};
    pr = t.data_byte >= kvp_pkg::PRINT_LO && t.data_byte <= kvp_pkg::PRINT_HI;
    if (pr) printable_seen = 1'b1;
    case (ph)
      PH_IDLE: if (pr) begin
        klen = 0;
        kbuf[0] = t.data_byte;
        klen = 1;
        ph = PH_KEY;
      end
      PH_KEY: if (pr) begin
        if (klen < KEY_MAX) kbuf[klen] = t.data_byte;
        if (klen <= KEY_MAX) klen++;
      end else close_key();
      PH_GAP: if (pr) begin
        take_value_char(t.data_byte);
        ph = PH_VALUE;
      end
      PH_VALUE: if (pr) take_value_char(t.data_byte);
      else begin
        add_pair(8'h0);
        ph = PH_IDLE;
      end
      PH_CKSUM: begin
        add_pair(t.data_byte);
        ph = PH_IDLE;
      end
      default: ph = PH_IDLE;
    endcase
    if (t.frame_end) begin
      if (ph == PH_KEY) close_key();
      if (ph == PH_GAP || ph == PH_VALUE) add_pair(8'h0);
      r = '0;
      r.frame_done = 1'b1;
      r.frame_empty = !printable_seen;
      step_out.push_back(r);
      reset_shadow();
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last_result = 1'b1;
    foreach (step_out[i]) expected_results.push_back(step_out[i]);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_byte('{in_data_byte, in_frame_end});
        void'(pending_bytes.pop_front());
      end
      if (pending_bytes.size() > 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
        in_push <= 1'b1;
        in_data_byte <= pending_bytes[0].data_byte;
        in_frame_end <= pending_bytes[0].frame_end;
      end else if (!(in_push && in_full)) begin
        in_push <= 1'b0;
        in_data_byte <= 8'($urandom);
        in_frame_end <= 1'($urandom);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_field_id, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_field_id !== want.field_id)
            report_mismatch("field_id", out_field_id, want.field_id);
          if (out_field_value !== want.field_value)
            report_mismatch("field_value", out_field_value, want.field_value);
          if (out_decoded_code !== want.decoded_code)
            report_mismatch("decoded_code", out_decoded_code, want.decoded_code);
          if (out_pair_valid !== want.pair_valid)
            report_mismatch("pair_valid", out_pair_valid, want.pair_valid);
          if (out_frame_done !== want.frame_done)
            report_mismatch("frame_done", out_frame_done, want.frame_done);
          if (out_frame_empty !== want.frame_empty)
            report_mismatch("frame_empty", out_frame_empty, want.frame_empty);
          if (out_last_result !== want.last_result)
            report_mismatch("last_result", out_last_result, want.last_result);
        end
      end
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles <= recv_hold_cycles - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** key_value_frame_parser: FAILED **");
        $finish;
      end
    end
  end

  task automatic push_text(string s, bit end_frame);
    for (int i = 0; i < s.len(); i++)
      pending_bytes.push_back('{s[i], end_frame && (i == s.len() - 1)});
  endtask

  task automatic push_pair(string k, string v);
    push_text({k, "\t", v, "\r\n"}, 1'b0);
  endtask

  function automatic string rand_token(int maxlen);
    string s;
    int n;
    s = "";
    n = $urandom_range(maxlen, 1);
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(126, 33)))};
    return s;
  endfunction

  function automatic string rand_value(int k);
    string pool[10] = '{"0", "1", "-", "+", "9", "7", "x", "a", "F", "5"};
    string s;
    int n;
    s = "";
    case ($urandom_range(5))
      0: return rand_token(14);
      1: return $sformatf("%0d", $signed($urandom));
      2: return $sformatf("0x%0h", $urandom);
      3: return (k == kvp_pkg::K_ERR) ? "116" : (k == kvp_pkg::K_LOAD) ? "ON" : "-2147483648";
      default: begin
        n = $urandom_range(13, 1);
        for (int i = 0; i < n; i++) s = {s, pool[$urandom_range(9)]};
        return s;
      end
    endcase
  endfunction

  task automatic push_random_frame();
    int pairs;
    int k;
    pairs = $urandom_range(4, 1);
    for (int p = 0; p < pairs; p++) begin
      k = $urandom_range(17);
      if ($urandom_range(9) == 0) push_pair(rand_token(11), rand_value(3));
      else push_pair(key_name(k), rand_value(k));
    end
    case ($urandom_range(4))
      0: push_text({"Checksum\t", string'(8'($urandom))}, 1'b1);
      1: push_text(rand_token(6), 1'b1);
      2: pending_bytes.push_back('{8'($urandom), 1'b1});
      3: push_text({key_name($urandom_range(17)), "\t", rand_value(3)}, 1'b1);
      default: begin
        for (int i = 0; i < 5; i++) pending_bytes.push_back('{8'($urandom), 1'b0});
        pending_bytes.push_back('{8'($urandom), 1'b1});
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_push || expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data_byte = 8'h0;
    in_frame_end = 1'b0;
    out_pop = 1'b0;
    error_count = 0;
    recv_hold_cycles = 0;
    send_hold = 1'b0;
    idle_cycles = 0;
    send_idle_pct = 38;
    recv_idle_pct = 88;
    reset_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    push_pair("PID", "0xA060");
    push_pair("V", "-2147483649");
    push_pair("I", "99999999999");
    push_pair("CS", "5");
    push_pair("ERR", "116");
    push_pair("LOAD", "ON");
    push_pair("LOAD", "OFF");
    push_pair("FW", "159");
    push_pair("ChecksumX", "1");
    push_pair("HSDS", "+12ab");
    push_text({"Checksum\t", 8'hff}, 1'b1);
    pending_bytes.push_back('{8'h20, 1'b1});
    pending_bytes.push_back('{8'h00, 1'b1});
    push_text("H19", 1'b1);
    push_text("PID\t-0Xff", 1'b1);
    push_text({"Checksum\t", 8'h00, "\tH20\t~"}, 1'b1);

    while (pending_bytes.size() < 200) push_random_frame();
    recv_hold_cycles = 60;
    wait_drained();

    send_idle_pct = 88;
    recv_idle_pct = 38;
    while (pending_bytes.size() < 200) push_random_frame();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (pending_bytes.size() < 220) push_random_frame();
    wait_drained();

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("** key_value_frame_parser: PASSED **");
    end else begin
      $display("** key_value_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule
